@@ design/cse_pkg.sv @@
// shared widths, constants and the status struct of the cosine similarity engine
// no dependencies; imported by cse_root, cosine_similarity_engine_top, cse_checker and tb
`default_nettype none

package cse_pkg;

    localparam int SUM_W  = 48;   // running sums
    localparam int HALF_W = 24;   // operand width of the shared multiplier
    localparam int PROD_W = 96;   // sumA*sumB and dot*dot
    localparam int WIDE_W = 128;  // compare domain of the root search
    localparam int COS_W  = 17;   // cosine, 16 fraction bits

    localparam logic [COS_W-1:0] ONE_FIX = 17'h10000;

    typedef struct packed {
        logic             done;
        logic [COS_W-1:0] cosine;
    } root_status_t;

endpackage

`default_nettype wire

@@ design/cse_mul.sv @@
// shared 24x24 unsigned multiplier with a registered product
// no dependencies
`default_nettype none

module cse_mul (
    input  wire logic        clk,
    input  wire logic [23:0] op_x,
    input  wire logic [23:0] op_y,
    output logic      [47:0] prod
);

    logic [47:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_x * op_y;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ design/cse_root.sv @@
// bit-serial search for the largest c <= 1.0 with c*c*p <= r * 2^32
// uses one shift/add/compare unit, with a trial step and a decide step per result bit; depends on cse_pkg
`default_nettype none

module cse_root
    import cse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] p_value,   // sumA * sumB
    input  wire logic [PROD_W-1:0] r_value,   // dot * dot
    output root_status_t           status
);

    logic [WIDE_W-1:0] q_reg, q_next;     // c*c*p
    logic [WIDE_W-1:0] ms_reg, ms_next;   // c*p shifted to the current bit
    logic [WIDE_W-1:0] ps_reg, ps_next;   // p shifted to the square of the current bit
    logic [PROD_W-1:0] r_reg, r_next;
    logic [WIDE_W+1:0] t_reg, t_next;     // trial square times p
    logic [COS_W-1:0]  c_reg, c_next;
    logic [COS_W-1:0]  mask_reg, mask_next;
    logic              phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              fits;

    assign fits = (t_reg <= {2'b00, r_reg, 32'd0});

    always_comb
    begin
        q_next     = q_reg;
        ms_next    = ms_reg;
        ps_next    = ps_reg;
        r_next     = r_reg;
        t_next     = t_reg;
        c_next     = c_reg;
        mask_next  = mask_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            q_next     = '0;
            ms_next    = '0;
            ps_next    = {p_value, 32'd0};
            r_next     = r_value;
            c_next     = '0;
            mask_next  = ONE_FIX;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                t_next     = {2'b00, q_reg} + {2'b00, ms_reg} + {2'b00, ps_reg};
                phase_next = 1'b1;
            end
            else
            begin
                // (c + m)^2 p = c^2 p + 2cmp + m^2 p
                if (fits)
                begin
                    q_next  = t_reg[WIDE_W-1:0];
                    ms_next = (ms_reg >> 1) + ps_reg;
                    c_next  = c_reg | mask_reg;
                end
                else
                begin
                    ms_next = ms_reg >> 1;
                end
                ps_next    = ps_reg >> 2;
                mask_next  = mask_reg >> 1;
                phase_next = 1'b0;
                // a fit at 1.0 is the cap
                if (mask_reg[0] || (fits && mask_reg[COS_W-1]))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        ms_reg   <= ms_next;
        ps_reg   <= ps_next;
        r_reg    <= r_next;
        t_reg    <= t_next;
        c_reg    <= c_next;
        mask_reg <= mask_next;
    end

    assign status.done   = done_reg;
    assign status.cosine = c_reg;

    a_one_bit_under_test: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot(mask_reg))
        else $error("search mask is not one-hot");

    a_done_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done raised while search still running");

    a_result_capped: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (c_reg <= ONE_FIX))
        else $error("cosine above 1.0");

    a_square_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !phase_reg && !start) |-> (q_reg <= {r_reg, 32'd0}))
        else $error("accepted square exceeds bound");

endmodule

`default_nettype wire

@@ design/cosine_similarity_engine_top.sv @@
// cosine similarity engine top: accumulators, sequencer and output register
// depends on cse_pkg, cse_mul and cse_root
//
// channel   dir   handshake                      payload
// s_axis    in    s_axis_tvalid / s_axis_tready  tdata: a_value, b_value; tlast: last
// m_axis    out   m_axis_tvalid / m_axis_tready  tdata: cosine; tuser: zero_norm
//
// an element pair steps through the accepting state, then a*b, a*a, b*b and the last add
// the last pair adds a norm check, 8 partial products, a trial and a decide step per result bit for 17 bits
// and control; the search ends early when the result caps at 1.0 and is skipped when a norm is zero
// reset clears the sums, the sequencer and the output valid
// a waiting result item does not stop accumulation of the next vector;
// only a new result waits until the output register is free
`default_nettype none

module cosine_similarity_engine_top
    import cse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] a_value, [31:16] b_value
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [16:0] cosine, [23:17] zero
    output logic             m_axis_tuser    // [0] zero_norm
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAB   = 4'd1;
    localparam logic [3:0] ST_MAA   = 4'd2;
    localparam logic [3:0] ST_MBB   = 4'd3;
    localparam logic [3:0] ST_ABB   = 4'd4;
    localparam logic [3:0] ST_CHECK = 4'd5;
    localparam logic [3:0] ST_PROD  = 4'd6;
    localparam logic [3:0] ST_PLAST = 4'd7;
    localparam logic [3:0] ST_START = 4'd8;
    localparam logic [3:0] ST_ROOT  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {1'b0, x};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [14:0]       a_reg, a_next;
    logic [14:0]       b_reg, b_next;
    logic              last_reg, last_next;
    logic [SUM_W-1:0]  dot_reg, dot_next;
    logic [SUM_W-1:0]  sa_reg, sa_next;
    logic [SUM_W-1:0]  sb_reg, sb_next;
    logic [2:0]        idx_reg, idx_next;
    logic [2:0]        tag_reg, tag_next;
    logic              tag_vld_reg, tag_vld_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic [PROD_W-1:0] r_reg, r_next;
    logic [COS_W-1:0]  res_cos_reg, res_cos_next;
    logic              res_zero_reg, res_zero_next;
    logic              out_vld_reg, out_vld_next;
    logic [COS_W-1:0]  out_cos_reg, out_cos_next;
    logic              out_zero_reg, out_zero_next;

    logic [HALF_W-1:0] op_x, op_y;
    logic [47:0]       prod;
    logic [SUM_W-1:0]  wx, wy;
    logic [PROD_W-1:0] prod_shifted;
    logic              root_start;
    root_status_t      root_status;
    logic              in_take;
    logic              out_free;

    cse_mul u_mul (
        .clk  (clk),
        .op_x (op_x),
        .op_y (op_y),
        .prod (prod)
    );

    cse_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .p_value (p_reg),
        .r_value (r_reg),
        .status  (root_status)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign root_start    = (state_reg == ST_START);

    // wide operand source: sums for sumA*sumB, dot for dot*dot
    assign wx = idx_reg[2] ? dot_reg : sa_reg;
    assign wy = idx_reg[2] ? dot_reg : sb_reg;

    always_comb
    begin
        case (state_reg)
            ST_MAB:
            begin
                op_x = {9'd0, a_reg};
                op_y = {9'd0, b_reg};
            end
            ST_MAA:
            begin
                op_x = {9'd0, a_reg};
                op_y = {9'd0, a_reg};
            end
            ST_MBB:
            begin
                op_x = {9'd0, b_reg};
                op_y = {9'd0, b_reg};
            end
            default:
            begin
                op_x = idx_reg[1] ? wx[SUM_W-1:HALF_W] : wx[HALF_W-1:0];
                op_y = idx_reg[0] ? wy[SUM_W-1:HALF_W] : wy[HALF_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        case (tag_reg[1:0])
            2'b00:   prod_shifted = {48'd0, prod};
            2'b11:   prod_shifted = {prod, 48'd0};
            default: prod_shifted = {24'd0, prod, 24'd0};
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        dot_next      = dot_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        idx_next      = idx_reg;
        tag_next      = idx_reg;
        tag_vld_next  = (state_reg == ST_PROD);
        p_next        = p_reg;
        r_next        = r_reg;
        res_cos_next  = res_cos_reg;
        res_zero_next = res_zero_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        out_cos_next  = out_cos_reg;
        out_zero_next = out_zero_reg;

        // partial products land in the cycle after issue
        if (tag_vld_reg)
        begin
            if (tag_reg[2])
                r_next = r_reg + prod_shifted;
            else
                p_next = p_reg + prod_shifted;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    // negative elements count as zero
                    a_next     = s_axis_tdata[15] ? 15'd0 : s_axis_tdata[14:0];
                    b_next     = s_axis_tdata[31] ? 15'd0 : s_axis_tdata[30:16];
                    last_next  = s_axis_tlast;
                    state_next = ST_MAB;
                end
            end
            ST_MAB:
            begin
                state_next = ST_MAA;
            end
            ST_MAA:
            begin
                dot_next   = sat_add(dot_reg, prod);
                state_next = ST_MBB;
            end
            ST_MBB:
            begin
                sa_next    = sat_add(sa_reg, prod);
                state_next = ST_ABB;
            end
            ST_ABB:
            begin
                sb_next    = sat_add(sb_reg, prod);
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if ((sa_reg == '0) || (sb_reg == '0))
                begin
                    res_cos_next  = '0;
                    res_zero_next = 1'b1;
                    dot_next      = '0;
                    sa_next       = '0;
                    sb_next       = '0;
                    state_next    = ST_OUT;
                end
                else
                begin
                    p_next     = '0;
                    r_next     = '0;
                    idx_next   = '0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                    state_next = ST_PLAST;
            end
            ST_PLAST:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                dot_next   = '0;
                sa_next    = '0;
                sb_next    = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_status.done)
                begin
                    res_cos_next  = root_status.cosine;
                    res_zero_next = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_cos_next  = res_cos_reg;
                    out_zero_next = res_zero_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dot_reg     <= '0;
            sa_reg      <= '0;
            sb_reg      <= '0;
            tag_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dot_reg     <= dot_next;
            sa_reg      <= sa_next;
            sb_reg      <= sb_next;
            tag_vld_reg <= tag_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        tag_reg      <= tag_next;
        p_reg        <= p_next;
        r_reg        <= r_next;
        res_cos_reg  <= res_cos_next;
        res_zero_reg <= res_zero_next;
        out_cos_reg  <= out_cos_next;
        out_zero_reg <= out_zero_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_cos_reg};
    assign m_axis_tuser  = out_zero_reg;

endmodule

`default_nettype wire

@@ sim/cse_checker.sv @@
// result checker for the cosine similarity engine: watches both stream channels,
// predicts each cosine item and compares it with what the block sends
// depends on cse_pkg for the sum and cosine widths

module cse_checker
    import cse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] a_value, [31:16] b_value
    input  wire logic        s_axis_tlast,   // last
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,   // [16:0] cosine, [23:17] zero
    input  wire logic        m_axis_tuser,   // [0] zero_norm
    output int               mismatches,
    output int               waiting,
    output int               checked
);

    localparam int WIDE = 192;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [COS_W-1:0] cosine;
        logic             zero_norm;
    } sim_result_t;

    sim_result_t      pending_cosines[$];
    logic [SUM_W-1:0] dot_acc;
    logic [SUM_W-1:0] a_sq_acc;
    logic [SUM_W-1:0] b_sq_acc;
    int               err_n;
    int               seen_n;

    // negative elements count as zero
    function automatic logic [15:0] elem_clamp(logic [15:0] raw);
        return raw[15] ? 16'd0 : raw;
    endfunction

    function automatic logic [SUM_W-1:0] sat_accum(logic [SUM_W-1:0] s, logic [31:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, s};
        t = t + x;
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    // largest c in [0, 1.0] with c*c*sa*sb <= 2^32 * dot*dot
    function automatic logic [COS_W-1:0] cosine_floor(logic [SUM_W-1:0] dot,
                                                      logic [SUM_W-1:0] sa,
                                                      logic [SUM_W-1:0] sb);
        logic [WIDE-1:0] norm_prod;
        logic [WIDE-1:0] dot_sq;
        logic [WIDE-1:0] lhs;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        norm_prod = WIDE'(sa) * WIDE'(sb);
        dot_sq    = (WIDE'(dot) * WIDE'(dot)) << 32;
        lo = 0;
        hi = ONE_FIX;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = WIDE'(mid) * WIDE'(mid) * norm_prod;
            if (lhs <= dot_sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[COS_W-1:0];
    endfunction

    function automatic void note_mismatch(string msg);
        err_n++;
        if (err_n <= 10)
            $display("mismatch: %s", msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sim_result_t got;
        sim_result_t want;
        logic [15:0] a;
        logic [15:0] b;
        if (!rst_n)
        begin
            pending_cosines.delete();
            dot_acc  = '0;
            a_sq_acc = '0;
            b_sq_acc = '0;
            err_n    = 0;
            seen_n   = 0;
        end
        else
        begin
            // result side first: a result never belongs to a pair taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.cosine    = m_axis_tdata[COS_W-1:0];
                got.zero_norm = m_axis_tuser;
                seen_n++;
                if (pending_cosines.size() == 0)
                    note_mismatch($sformatf("unexpected item: cosine %0d zero_norm %0d",
                                            got.cosine, got.zero_norm));
                else
                begin
                    want = pending_cosines.pop_front();
                    if (got != want)
                        note_mismatch($sformatf(
                            "expected cosine %0d zero_norm %0d, got cosine %0d zero_norm %0d",
                            want.cosine, want.zero_norm, got.cosine, got.zero_norm));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                a = elem_clamp(s_axis_tdata[15:0]);
                b = elem_clamp(s_axis_tdata[31:16]);
                dot_acc  = sat_accum(dot_acc,  32'(a) * 32'(b));
                a_sq_acc = sat_accum(a_sq_acc, 32'(a) * 32'(a));
                b_sq_acc = sat_accum(b_sq_acc, 32'(b) * 32'(b));
                if (s_axis_tlast)
                begin
                    if (a_sq_acc == '0 || b_sq_acc == '0)
                    begin
                        want.cosine    = '0;
                        want.zero_norm = 1'b1;
                    end
                    else
                    begin
                        want.cosine    = cosine_floor(dot_acc, a_sq_acc, b_sq_acc);
                        want.zero_norm = 1'b0;
                    end
                    pending_cosines.push_back(want);
                    dot_acc  = '0;
                    a_sq_acc = '0;
                    b_sq_acc = '0;
                end
            end
        end
        mismatches <= err_n;
        waiting    <= pending_cosines.size();
        checked    <= seen_n;
    end

endmodule

@@ sim/tb.sv @@
// testbench top for the cosine similarity engine: clock, reset, pair stimulus
// and output back-pressure; depends on cse_pkg, the engine rtl and cse_checker

module tb;
    import cse_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 1200;
    localparam int PHASE_PAIRS  = 140;

    typedef enum int {MODE_POS, MODE_ANY, MODE_TINY, MODE_EXTREME} elem_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    int   cycle_count = 0;
    int   pairs_sent = 0;
    int   vectors_sent = 0;
    int   mismatches;
    int   waiting;
    int   checked;
    int   idle_tab[4]  = '{0, 56, 0, 35};
    int   stall_tab[4] = '{0, 0, 56, 35};

    cosine_similarity_engine_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cse_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .waiting       (waiting),
        .checked       (checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pairs_sent++;
        if (lst)
            vectors_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_elem(elem_mode_t mode);
        case (mode)
            MODE_POS:  return 16'($urandom_range(0, 32767));
            MODE_ANY:  return 16'($urandom);
            MODE_TINY: return 16'($urandom_range(0, 15));
            default:
                case ($urandom_range(0, 4))
                    0:       return 16'h0000;
                    1:       return 16'h0001;
                    2:       return 16'h7fff;
                    3:       return 16'h8000;
                    default: return 16'hffff;
                endcase
        endcase
    endfunction

    task automatic send_random_vector();
        int         len;
        int         pick;
        int         shift;
        elem_mode_t mode_a;
        elem_mode_t mode_b;
        logic       b_tracks_a;
        logic       a_silent;
        logic [15:0] a;
        logic [15:0] b;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        pick = $urandom_range(0, 9);
        mode_a = (pick < 6) ? MODE_POS : (pick == 6) ? MODE_ANY :
                 (pick == 7) ? MODE_TINY : MODE_EXTREME;
        mode_b = ($urandom_range(0, 3) == 0) ? elem_mode_t'($urandom_range(0, 3)) : mode_a;
        b_tracks_a = ($urandom_range(0, 4) == 0);
        a_silent   = ($urandom_range(0, 19) == 0);
        shift = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            a = a_silent ? 16'h0000 : pick_elem(mode_a);
            // b a scaled copy of a gives a cosine at or near one
            if (b_tracks_a)
                b = a[15] ? a : (a >> shift);
            else
                b = pick_elem(mode_b);
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial
    begin
        int goal;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pair vectors: collinear extremes, zero norms, negatives as zero
        send_pair(16'h7fff, 16'h7fff, 1'b1);
        send_pair(16'h0001, 16'h7fff, 1'b1);
        send_pair(16'h0000, 16'h0005, 1'b1);
        send_pair(16'hffff, 16'h0064, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0064, 16'h8001, 1'b1);
        // orthogonal vectors
        send_pair(16'h0005, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0007, 1'b1);
        // nearly orthogonal with a small nonzero cosine, then a vector pair at 24/25
        send_pair(16'h7fff, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'h7fff, 1'b1);
        send_pair(16'h0003, 16'h0004, 1'b0);
        send_pair(16'h0004, 16'h0003, 1'b1);
        // negatives mixed into a longer vector
        send_pair(16'hfffb, 16'h0003, 1'b0);
        send_pair(16'h0004, 16'h0004, 1'b0);
        send_pair(16'h7fff, 16'h8000, 1'b1);
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'h0002, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            goal = pairs_sent + PHASE_PAIRS;
            while (pairs_sent < goal)
                send_random_vector();
        end

        // receiver holds off while short vectors keep coming, so the input backs up
        idle_pct  = 0;
        stall_pct = 0;
        s_axis_tvalid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        for (int i = 0; i < 40; i++)
            send_pair(pick_elem(MODE_POS), pick_elem(MODE_POS), ($urandom_range(0, 2) != 0));
        send_pair(pick_elem(MODE_POS), pick_elem(MODE_POS), 1'b1);

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d pairs in %0d vectors, %0d cosine items checked, %0d mismatches",
                 pairs_sent, vectors_sent, checked, mismatches);
        $display("summary: extremes and zero norms, four idle mixes, long hold-off");
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
